/* sv/hpr_pkg.sv */
// package: constants, codes and shared types of the heat-pump frame receiver
package hpr_pkg;

    localparam int KEPT_DATA_BYTES = 12;
    localparam int COUNT_BITS      = 9;
    localparam int IDX_BITS        = $clog2(KEPT_DATA_BYTES);

    localparam logic [7:0] HDR_BYTE      = 8'hFC;
    localparam int         HDR_LEN       = 5;
    localparam logic [7:0] INFO_SETTINGS = 8'h02;
    localparam logic [7:0] INFO_ROOM     = 8'h03;
    localparam logic [7:0] INFO_STATUS   = 8'h06;
    localparam logic [7:0] NEED_SETTINGS = 8'd12;
    localparam logic [7:0] NEED_ROOM     = 8'd7;
    localparam logic [7:0] NEED_STATUS   = 8'd5;
    localparam logic [7:0] TEMP_FLIP     = 8'h80;
    localparam logic [7:0] TARGET_BASE   = 8'd62;
    localparam logic [7:0] ROOM_BASE     = 8'd20;
    localparam logic [7:0] ROOM_IDX_MAX  = 8'd31;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_HDR      = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_BAD_SUM      = 3'd4
    } t_status;

    typedef logic [KEPT_DATA_BYTES-1:0][7:0] t_data;

    typedef struct packed {
        t_status    status;
        logic [7:0] frame_type;
        logic [7:0] length;
        t_data      data;
    } t_check;

    typedef struct packed {
        logic       power_on;
        logic [2:0] mode_code;
        logic [7:0] fan_code;
        logic [7:0] vane_code;
        logic [3:0] wide_vane_code;
        logic [7:0] target_half_deg;
        logic [7:0] room_half_deg;
        logic       compressor_running;
        logic [7:0] compressor_hz;
    } t_readings;

endpackage

/* sv/hpr_if.sv */
// interfaces: received byte channel and frame result channel

interface hpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface hpr_res_if;
    logic              valid;
    logic              ready;
    logic [2:0]        frame_status;
    logic [7:0]        frame_type;
    logic              readings_changed;
    logic              power_on;
    logic [2:0]        mode_code;
    logic [7:0]        fan_code;
    logic [7:0]        vane_code;
    logic [3:0]        wide_vane_code;
    logic signed [7:0] target_half_deg;
    logic signed [7:0] room_half_deg;
    logic              compressor_running;
    logic [7:0]        compressor_hz;

    modport source (output valid, output frame_status, output frame_type,
                    output readings_changed, output power_on, output mode_code,
                    output fan_code, output vane_code, output wide_vane_code,
                    output target_half_deg, output room_half_deg,
                    output compressor_running, output compressor_hz, input ready);
    modport sink   (input valid, input frame_status, input frame_type,
                    input readings_changed, input power_on, input mode_code,
                    input fan_code, input vane_code, input wide_vane_code,
                    input target_half_deg, input room_half_deg,
                    input compressor_running, input compressor_hz, output ready);
endinterface

/* sv/heat_pump_serial_frame_receiver.sv */
// top level: heat-pump serial frame receiver with input and result registers
// path: a frame's last byte is held in the input register, then its result is registered in the output register
// throughput: one byte per cycle; a result waiting in the output register stalls
// only a following last byte, other bytes keep flowing
// reset: synchronous active-low i_rst_n clears the frame count, sum, header fields
// and all kept readings; the data byte store is not cleared
module heat_pump_serial_frame_receiver
    import hpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hpr_rx_if.sink    i_rx,
    hpr_res_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       r_out_valid;
    t_status    r_out_status;
    logic [7:0] r_out_type;
    logic       r_out_changed;
    t_readings  r_out_rd;

    logic      w_adv;
    logic      w_step;
    logic      w_go;
    t_check    w_check;
    t_readings w_next;
    logic      w_changed;

    assign w_adv  = !r_in_end || !r_out_valid || o_res.ready;
    assign w_step = r_in_valid && w_adv;
    assign w_go   = w_step && r_in_end && (w_check.status == ST_OK);

    assign i_rx.ready = !r_in_valid || w_adv;

    hpr_frame_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_check (w_check)
    );

    hpr_readings u_rd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_check   (w_check),
        .o_next    (w_next),
        .o_changed (w_changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_end  <= i_rx.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_end) begin
            r_out_status  <= w_check.status;
            r_out_type    <= w_check.frame_type;
            r_out_changed <= w_changed;
            r_out_rd      <= w_next;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.frame_status       = r_out_status;
    assign o_res.frame_type         = r_out_type;
    assign o_res.readings_changed   = r_out_changed;
    assign o_res.power_on           = r_out_rd.power_on;
    assign o_res.mode_code          = r_out_rd.mode_code;
    assign o_res.fan_code           = r_out_rd.fan_code;
    assign o_res.vane_code          = r_out_rd.vane_code;
    assign o_res.wide_vane_code     = r_out_rd.wide_vane_code;
    assign o_res.target_half_deg    = r_out_rd.target_half_deg;
    assign o_res.room_half_deg      = r_out_rd.room_half_deg;
    assign o_res.compressor_running = r_out_rd.compressor_running;
    assign o_res.compressor_hz      = r_out_rd.compressor_hz;

    // a failed frame never reports a change
    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == ST_OK) || !r_out_changed)
        else $error("changed flag set on a failed frame");

    // a last byte leaving the input register always produces a result
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_end) |=> r_out_valid)
        else $error("last byte did not produce a result");

    // input stalls only behind a last byte waiting on a full output register
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> r_in_valid && r_in_end && r_out_valid && !o_res.ready)
        else $error("input stalled without cause");

    // an ordinary byte never touches the result register
    a_mid_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(w_step && r_in_end)) |=> !r_out_valid)
        else $error("result appeared without a last byte");

endmodule

/* sv/hpr_frame_acc.sv */
// frame accumulator: byte count, running sum, header fields, data bytes and frame check
module hpr_frame_acc
    import hpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_check     o_check
);

    logic [COUNT_BITS-1:0] r_count;
    logic [7:0]            r_sum;
    logic                  r_hdr_ok;
    logic [7:0]            r_type;
    logic [7:0]            r_len;
    t_data                 r_data;

    logic [COUNT_BITS-1:0] w_total;
    logic [COUNT_BITS-1:0] w_off;
    logic                  w_store;
    logic                  w_hdr_ok;
    logic [7:0]            w_len;

    assign w_off   = r_count - COUNT_BITS'(HDR_LEN);
    assign w_store = (r_count >= COUNT_BITS'(HDR_LEN)) &&
                     (w_off < COUNT_BITS'(KEPT_DATA_BYTES));
    assign w_total = (r_count < COUNT_MAX) ? r_count + 1'b1 : COUNT_MAX;
    assign w_hdr_ok = (r_count == '0) ? (i_byte == HDR_BYTE) : r_hdr_ok;
    assign w_len    = (r_count == COUNT_BITS'(4)) ? i_byte : r_len;

    always_comb begin
        o_check.frame_type = (r_count == COUNT_BITS'(1)) ? i_byte : r_type;
        o_check.length     = w_len;
        o_check.data       = r_data;
        if (w_total < COUNT_BITS'(HDR_LEN + 1)) begin
            o_check.status = ST_SHORT;
        end else if (!w_hdr_ok) begin
            o_check.status = ST_BAD_HDR;
        end else if (w_total != COUNT_BITS'(w_len) + COUNT_BITS'(HDR_LEN + 1)) begin
            o_check.status = ST_LEN_MISMATCH;
        end else if (8'(HDR_BYTE - r_sum) != i_byte) begin
            o_check.status = ST_BAD_SUM;
        end else begin
            o_check.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b0;
            r_type   <= '0;
            r_len    <= '0;
        end else if (i_step) begin
            if (i_end) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_hdr_ok <= 1'b0;
                r_type   <= '0;
                r_len    <= '0;
            end else begin
                r_sum    <= r_sum + i_byte;
                r_hdr_ok <= w_hdr_ok;
                r_len    <= w_len;
                if (r_count == COUNT_BITS'(1)) begin
                    r_type <= i_byte;
                end
                if (r_count < COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_store) begin
            r_data[w_off[IDX_BITS-1:0]] <= i_byte;
        end
    end

endmodule

/* sv/hpr_readings.sv */
// kept readings: decode of settings, room temperature and status responses
module hpr_readings
    import hpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_check    i_check,
    output t_readings o_next,
    output logic      o_changed
);

    t_readings r_kept;
    logic      r_room_seen;

    t_data      w_d;
    logic [7:0] w_len;
    logic [7:0] w_target;
    logic [7:0] w_room;
    logic [4:0] w_room_idx;
    logic       w_run;
    logic       w_room_dec;

    assign w_d   = i_check.data;
    assign w_len = i_check.length;

    assign w_target   = (w_d[11] != 8'd0) ? (w_d[11] ^ TEMP_FLIP)
                                          : TARGET_BASE - {3'b000, w_d[5][3:0], 1'b0};
    assign w_room_idx = (w_d[3] > ROOM_IDX_MAX) ? ROOM_IDX_MAX[4:0] : w_d[3][4:0];
    assign w_room     = (w_d[6] != 8'd0) ? (w_d[6] ^ TEMP_FLIP)
                                         : ROOM_BASE + {2'b00, w_room_idx, 1'b0};
    assign w_run      = (w_d[4] != 8'd0);

    always_comb begin
        o_next     = r_kept;
        o_changed  = 1'b0;
        w_room_dec = 1'b0;
        if (i_go) begin
            if (w_d[0] == INFO_SETTINGS && w_len >= NEED_SETTINGS) begin
                o_next.power_on        = w_d[3][0];
                o_next.mode_code       = w_d[4][2:0];
                o_next.fan_code        = w_d[6];
                o_next.vane_code       = w_d[7];
                o_next.wide_vane_code  = w_d[10][3:0];
                o_next.target_half_deg = w_target;
                o_changed = (o_next != r_kept);
            end else if (w_d[0] == INFO_ROOM && w_len >= NEED_ROOM) begin
                o_next.room_half_deg = w_room;
                w_room_dec = 1'b1;
                o_changed  = (w_room != r_kept.room_half_deg) || !r_room_seen;
            end else if (w_d[0] == INFO_STATUS && w_len >= NEED_STATUS) begin
                o_next.compressor_running = w_run;
                o_next.compressor_hz      = w_run ? w_d[3] : 8'd0;
                o_changed = (o_next != r_kept);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept      <= '0;
            r_room_seen <= 1'b0;
        end else begin
            r_kept <= o_next;
            if (w_room_dec) begin
                r_room_seen <= 1'b1;
            end
        end
    end

endmodule
